// ===== rtl/rpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rpt_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_WIDTH     = 16;
    localparam int COORD_WIDTH    = 32;

    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = (COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH;

    // fraction bits of a quaternion product and of the rotation matrix
    localparam int RF      = 2 * QUAT_FRAC_BITS;
    localparam int PROD_W  = 2 * QUAT_WIDTH;
    localparam int ROT_W   = (PROD_W + 2 > RF + 2) ? PROD_W + 2 : RF + 2;

    // point operand (v or v - t) is split into an unsigned low and a signed high half
    localparam int OPND_W  = COORD_WIDTH + 1;
    localparam int LO_W    = OPND_W / 2;
    localparam int HI_W    = OPND_W - LO_W;
    localparam int PP_W    = ROT_W + LO_W + 1;
    localparam int SUM_W   = PP_W + 2;
    localparam int ACC_W   = ((SUM_W + LO_W > COORD_WIDTH + RF) ?
                              SUM_W + LO_W : COORD_WIDTH + RF) + 2;
    localparam int SH_W    = ACC_W - RF;

    localparam int PIPE_STAGES = 5;

    typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ROT_W-1:0]       rot_elem_t;
    typedef logic signed [OPND_W-1:0]      opnd_t;
    typedef logic signed [PP_W-1:0]        pp_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    localparam quat_t     QUAT_ONE  = QUAT_WIDTH'(1) << QUAT_FRAC_BITS;
    localparam rot_elem_t ROT_ONE   = ROT_W'(1) << RF;
    localparam acc_t      ACC_HALF  = ACC_W'(1) << (RF - 1);
    localparam coord_t    COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam coord_t    COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_QUAT_W  = CFG_IDX_WIDTH'(0),
        CFG_QUAT_X  = CFG_IDX_WIDTH'(1),
        CFG_QUAT_Y  = CFG_IDX_WIDTH'(2),
        CFG_QUAT_Z  = CFG_IDX_WIDTH'(3),
        CFG_TRANS_X = CFG_IDX_WIDTH'(4),
        CFG_TRANS_Y = CFG_IDX_WIDTH'(5),
        CFG_TRANS_Z = CFG_IDX_WIDTH'(6)
    } cfg_index_t;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_ld_t;

endpackage

`default_nettype wire

// ===== rtl/rpt_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpt_cfg
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rpt_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [rpt_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    output rpt_pkg::coord_t                         trans [3],
    output rpt_pkg::rot_elem_t                      rot [3][3]
);

    rpt_pkg::quat_t     quat_w_reg;
    rpt_pkg::quat_t     quat_x_reg;
    rpt_pkg::quat_t     quat_y_reg;
    rpt_pkg::quat_t     quat_z_reg;
    rpt_pkg::coord_t    trans_reg [3];
    rpt_pkg::rot_elem_t rot_reg [3][3];
    rpt_pkg::rot_elem_t rot_next [3][3];

    rpt_pkg::prod_t xx, yy, zz, xy, xz, yz, wx, wy, wz;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_w_reg <= rpt_pkg::QUAT_ONE;
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                trans_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (rpt_pkg::cfg_index_t'(cfg_index))
                rpt_pkg::CFG_QUAT_W:  quat_w_reg   <= cfg_data[rpt_pkg::QUAT_WIDTH-1:0];
                rpt_pkg::CFG_QUAT_X:  quat_x_reg   <= cfg_data[rpt_pkg::QUAT_WIDTH-1:0];
                rpt_pkg::CFG_QUAT_Y:  quat_y_reg   <= cfg_data[rpt_pkg::QUAT_WIDTH-1:0];
                rpt_pkg::CFG_QUAT_Z:  quat_z_reg   <= cfg_data[rpt_pkg::QUAT_WIDTH-1:0];
                rpt_pkg::CFG_TRANS_X: trans_reg[0] <= cfg_data[rpt_pkg::COORD_WIDTH-1:0];
                rpt_pkg::CFG_TRANS_Y: trans_reg[1] <= cfg_data[rpt_pkg::COORD_WIDTH-1:0];
                rpt_pkg::CFG_TRANS_Z: trans_reg[2] <= cfg_data[rpt_pkg::COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        xx = quat_x_reg * quat_x_reg;
        yy = quat_y_reg * quat_y_reg;
        zz = quat_z_reg * quat_z_reg;
        xy = quat_x_reg * quat_y_reg;
        xz = quat_x_reg * quat_z_reg;
        yz = quat_y_reg * quat_z_reg;
        wx = quat_w_reg * quat_x_reg;
        wy = quat_w_reg * quat_y_reg;
        wz = quat_w_reg * quat_z_reg;

        // R = I + 2w[u]x + 2[u]x^2, exact in Q(2*frac)
        rot_next[0][0] = rpt_pkg::ROT_ONE -
                         ((rpt_pkg::ROT_W'(yy) + rpt_pkg::ROT_W'(zz)) <<< 1);
        rot_next[0][1] = (rpt_pkg::ROT_W'(xy) - rpt_pkg::ROT_W'(wz)) <<< 1;
        rot_next[0][2] = (rpt_pkg::ROT_W'(xz) + rpt_pkg::ROT_W'(wy)) <<< 1;
        rot_next[1][0] = (rpt_pkg::ROT_W'(xy) + rpt_pkg::ROT_W'(wz)) <<< 1;
        rot_next[1][1] = rpt_pkg::ROT_ONE -
                         ((rpt_pkg::ROT_W'(xx) + rpt_pkg::ROT_W'(zz)) <<< 1);
        rot_next[1][2] = (rpt_pkg::ROT_W'(yz) - rpt_pkg::ROT_W'(wx)) <<< 1;
        rot_next[2][0] = (rpt_pkg::ROT_W'(xz) - rpt_pkg::ROT_W'(wy)) <<< 1;
        rot_next[2][1] = (rpt_pkg::ROT_W'(yz) + rpt_pkg::ROT_W'(wx)) <<< 1;
        rot_next[2][2] = rpt_pkg::ROT_ONE -
                         ((rpt_pkg::ROT_W'(xx) + rpt_pkg::ROT_W'(yy)) <<< 1);
    end

    // matrix register follows the quaternion registers in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rot_reg[i][j] <= (i == j) ? rpt_pkg::ROT_ONE : '0;
                end
            end
        end
        else
        begin
            rot_reg <= rot_next;
        end
    end

    assign trans = trans_reg;
    assign rot   = rot_reg;

endmodule

`default_nettype wire

// ===== rtl/rpt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpt_ctrl
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        point_valid,
    output logic             point_stall,
    output logic             result_valid,
    input  wire logic        result_stall,
    output rpt_pkg::pipe_ld_t ld
);

    logic [rpt_pkg::PIPE_STAGES-1:0] v_reg;
    logic [rpt_pkg::PIPE_STAGES-1:0] v_next;
    logic [rpt_pkg::PIPE_STAGES-1:0] rdy;
    logic [rpt_pkg::PIPE_STAGES-1:0] upstream;
    logic [rpt_pkg::PIPE_STAGES-1:0] ld_vec;

    // a stage takes new data when empty or when its content moves on
    always_comb
    begin
        rdy[rpt_pkg::PIPE_STAGES-1] = !v_reg[rpt_pkg::PIPE_STAGES-1] || !result_stall;
        for (int k = rpt_pkg::PIPE_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        upstream = {v_reg[rpt_pkg::PIPE_STAGES-2:0], point_valid};
        ld_vec   = rdy & upstream;
        for (int k = 0; k < rpt_pkg::PIPE_STAGES; k++)
        begin
            v_next[k] = rdy[k] ? upstream[k] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign point_stall  = !rdy[0];
    assign result_valid = v_reg[rpt_pkg::PIPE_STAGES-1];
    assign ld.s1 = ld_vec[0];
    assign ld.s2 = ld_vec[1];
    assign ld.s3 = ld_vec[2];
    assign ld.s4 = ld_vec[3];
    assign ld.s5 = ld_vec[4];

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> v_reg[0])
        else $error("input stalled with first stage empty");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !point_stall) |=> v_reg[0])
        else $error("accepted transaction missing from first stage");

    a_bubble_collapse: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && !v_reg[4]) |=> v_reg[4])
        else $error("item did not advance into empty output stage");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !v_reg[3]) |=> !result_valid)
        else $error("result repeated after transaction");
`endif

endmodule

`default_nettype wire

// ===== rtl/rpt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpt_front
(
    input  wire logic               clk,
    input  wire rpt_pkg::pipe_ld_t  ld,
    input  wire logic               kind,
    input  wire rpt_pkg::coord_t    point_x,
    input  wire rpt_pkg::coord_t    point_y,
    input  wire rpt_pkg::coord_t    point_z,
    input  wire rpt_pkg::coord_t    trans [3],
    input  wire rpt_pkg::rot_elem_t rot [3][3],
    output logic                    kind_s2,
    output rpt_pkg::pp_t            ppl [3][3],
    output rpt_pkg::pp_t            pph [3][3]
);

    rpt_pkg::coord_t pt [3];
    rpt_pkg::opnd_t  opnd_next [3];
    rpt_pkg::opnd_t  opnd1_reg [3];
    logic            kind1_reg;
    logic            kind2_reg;
    rpt_pkg::pp_t    ppl_next [3][3];
    rpt_pkg::pp_t    pph_next [3][3];
    rpt_pkg::pp_t    ppl_reg [3][3];
    rpt_pkg::pp_t    pph_reg [3][3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    // stage 1: inverse works on v - t
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            opnd_next[j] = kind ? rpt_pkg::OPND_W'(pt[j]) - rpt_pkg::OPND_W'(trans[j])
                                : rpt_pkg::OPND_W'(pt[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            kind1_reg <= kind;
            opnd1_reg <= opnd_next;
        end
    end

    // stage 2: matrix entry times low and high half of the operand;
    // inverse reads the transpose
    always_comb
    begin
        rpt_pkg::rot_elem_t              m;
        logic signed [rpt_pkg::LO_W:0]   lo;
        logic signed [rpt_pkg::HI_W-1:0] hi;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m  = kind1_reg ? rot[j][i] : rot[i][j];
                lo = {1'b0, opnd1_reg[j][rpt_pkg::LO_W-1:0]};
                hi = opnd1_reg[j][rpt_pkg::OPND_W-1:rpt_pkg::LO_W];
                ppl_next[i][j] = m * lo;
                pph_next[i][j] = m * hi;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s2)
        begin
            kind2_reg <= kind1_reg;
            ppl_reg   <= ppl_next;
            pph_reg   <= pph_next;
        end
    end

    assign kind_s2 = kind2_reg;
    assign ppl     = ppl_reg;
    assign pph     = pph_reg;

endmodule

`default_nettype wire

// ===== rtl/rpt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpt_back
(
    input  wire logic               clk,
    input  wire rpt_pkg::pipe_ld_t  ld,
    input  wire logic               kind_s2,
    input  wire rpt_pkg::pp_t       ppl [3][3],
    input  wire rpt_pkg::pp_t       pph [3][3],
    input  wire rpt_pkg::coord_t    trans [3],
    output rpt_pkg::coord_t         out_x,
    output rpt_pkg::coord_t         out_y,
    output rpt_pkg::coord_t         out_z
);

    logic              kind3_reg;
    rpt_pkg::sum_t     sl_next [3];
    rpt_pkg::sum_t     sh_next [3];
    rpt_pkg::sum_t     sl_reg [3];
    rpt_pkg::sum_t     sh_reg [3];
    rpt_pkg::acc_t     acc_next [3];
    rpt_pkg::acc_t     acc_reg [3];
    rpt_pkg::coord_t   res_next [3];
    rpt_pkg::coord_t   res_reg [3];

    // stage 3: row sums of the low and high partial products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sl_next[i] = rpt_pkg::SUM_W'(ppl[i][0]) + rpt_pkg::SUM_W'(ppl[i][1]) +
                         rpt_pkg::SUM_W'(ppl[i][2]);
            sh_next[i] = rpt_pkg::SUM_W'(pph[i][0]) + rpt_pkg::SUM_W'(pph[i][1]) +
                         rpt_pkg::SUM_W'(pph[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s3)
        begin
            kind3_reg <= kind_s2;
            sl_reg    <= sl_next;
            sh_reg    <= sh_next;
        end
    end

    // stage 4: merge halves, forward adds t at full precision, plus rounding half
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = (rpt_pkg::ACC_W'(sh_reg[i]) <<< rpt_pkg::LO_W) +
                          rpt_pkg::ACC_W'(sl_reg[i]) +
                          (kind3_reg ? '0 : (rpt_pkg::ACC_W'(trans[i]) <<< rpt_pkg::RF)) +
                          rpt_pkg::ACC_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s4)
        begin
            acc_reg <= acc_next;
        end
    end

    // stage 5: floor shift and saturate
    always_comb
    begin
        logic [rpt_pkg::SH_W-1:0]                        shifted;
        logic [rpt_pkg::SH_W-rpt_pkg::COORD_WIDTH:0]     top;
        for (int i = 0; i < 3; i++)
        begin
            shifted = acc_reg[i][rpt_pkg::ACC_W-1:rpt_pkg::RF];
            top     = shifted[rpt_pkg::SH_W-1:rpt_pkg::COORD_WIDTH-1];
            if ((&top) || !(|top))
            begin
                res_next[i] = shifted[rpt_pkg::COORD_WIDTH-1:0];
            end
            else
            begin
                res_next[i] = shifted[rpt_pkg::SH_W-1] ? rpt_pkg::COORD_MIN
                                                       : rpt_pkg::COORD_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s5)
        begin
            res_reg <= res_next;
        end
    end

    assign out_x = res_reg[0];
    assign out_y = res_reg[1];
    assign out_z = res_reg[2];

endmodule

`default_nettype wire

// ===== rtl/rigid_point_transform_unit.sv =====
// Channel   Direction  Handshake                       Payload
// point     in         point_valid / point_stall       kind, point_x, point_y, point_z
// result    out        result_valid / result_stall     out_x, out_y, out_z
// cfg       in         cfg_valid / cfg_ready (always)  cfg_index, cfg_data
//
// One point per cycle sustained while result_stall is low; result_valid rises once
// the point has been loaded into the last (shift and saturate) stage register.
// The five register stages are: operand prep, 18 partial products, row sums,
// translate and round bias, shift and saturate.
// Rotation matrix is rebuilt from the quaternion in the cycle after a cfg write.
// Async active-low reset empties the pipeline and loads the identity transform.
// result_stall backs up stage by stage; empty stages still accept while output waits.
`timescale 1ns / 1ps
`default_nettype none

module rigid_point_transform_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               point_valid,
    output logic                                    point_stall,
    input  wire logic                               kind,
    input  wire rpt_pkg::coord_t                    point_x,
    input  wire rpt_pkg::coord_t                    point_y,
    input  wire rpt_pkg::coord_t                    point_z,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output rpt_pkg::coord_t                         out_x,
    output rpt_pkg::coord_t                         out_y,
    output rpt_pkg::coord_t                         out_z,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rpt_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [rpt_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    rpt_pkg::pipe_ld_t  ld;
    rpt_pkg::coord_t    trans [3];
    rpt_pkg::rot_elem_t rot [3][3];
    logic               kind_s2;
    rpt_pkg::pp_t       ppl [3][3];
    rpt_pkg::pp_t       pph [3][3];

    rpt_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ld           (ld)
    );

    rpt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .trans     (trans),
        .rot       (rot)
    );

    rpt_front u_front
    (
        .clk     (clk),
        .ld      (ld),
        .kind    (kind),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .trans   (trans),
        .rot     (rot),
        .kind_s2 (kind_s2),
        .ppl     (ppl),
        .pph     (pph)
    );

    rpt_back u_back
    (
        .clk     (clk),
        .ld      (ld),
        .kind_s2 (kind_s2),
        .ppl     (ppl),
        .pph     (pph),
        .trans   (trans),
        .out_x   (out_x),
        .out_y   (out_y),
        .out_z   (out_z)
    );

endmodule

`default_nettype wire
